[rtl/core/assert_macros.svh]
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every edge out of reset
`define LRUFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// overlapping implication
`define LRUFR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/lrufr_pkg.sv]
package lrufr_pkg;

    localparam int FRAMES    = 16;
    localparam int FRAME_IDS = 16;
    localparam int FRAME_W   = 4;
    localparam int IDX_W     = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_PIN    = 2'd1,
        OP_UNPIN  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [FRAME_W-1:0] frame_index;
    } t_request;

    typedef struct packed {
        logic               victim_valid;
        logic [FRAME_W-1:0] victim_frame;
        logic [CNT_W-1:0]   occupancy;
    } t_result;

    typedef struct packed {
        logic [FRAME_IDS-1:0] member_mask;
        logic [CNT_W-1:0]     entry_count;
    } t_status;

endpackage

[rtl/core/lrufr_req_if.sv]
interface lrufr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [3:0] frame_index;

    modport source (output valid, output op, output frame_index, input ready);
    modport sink   (input valid, input op, input frame_index, output ready);
endinterface

[rtl/core/lrufr_rsp_if.sv]
interface lrufr_rsp_if;
    logic       valid;
    logic       ready;
    logic       victim_valid;
    logic [3:0] victim_frame;
    logic [4:0] occupancy;

    modport source (output valid, output victim_valid, output victim_frame,
                    output occupancy, input ready);
    modport sink   (input valid, input victim_valid, input victim_frame,
                    input occupancy, output ready);
endinterface

[rtl/core/lrufr_core.sv]
module lrufr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  lrufr_pkg::t_request i_req,
    output lrufr_pkg::t_result  o_res,
    output lrufr_pkg::t_status  o_status
);
    import lrufr_pkg::*;

    logic [FRAME_W-1:0]   r_list [FRAMES];
    logic [FRAME_W-1:0]   n_list [FRAMES];
    logic [FRAME_IDS-1:0] r_mask, n_mask;
    logic [CNT_W-1:0]     r_count, n_count;

    logic [FRAMES-1:0]    sel;
    logic [FRAMES-1:0]    after;
    logic                 do_remove;
    logic                 do_append;
    logic [FRAME_W-1:0]   oldest;

    always_comb begin
        oldest    = r_list[0];
        n_mask    = r_mask;
        n_count   = r_count;
        do_remove = 1'b0;
        do_append = 1'b0;
        o_res     = '0;

        // position of the requested frame among the held entries
        for (int i = 0; i < FRAMES; i++) begin
            sel[i] = (CNT_W'(i) < r_count) && (r_list[i] == i_req.frame_index);
        end

        unique case (i_req.op)
            OP_VICTIM: begin
                if (r_count != '0) begin
                    sel              = FRAMES'(1);
                    do_remove        = 1'b1;
                    n_mask[oldest]   = 1'b0;
                    o_res.victim_valid = 1'b1;
                    o_res.victim_frame = oldest;
                end
            end
            OP_PIN: begin
                if (r_mask[i_req.frame_index]) begin
                    do_remove                  = 1'b1;
                    n_mask[i_req.frame_index]  = 1'b0;
                end
            end
            OP_UNPIN: begin
                if (!r_mask[i_req.frame_index] && (r_count < CNT_W'(FRAMES))) begin
                    do_append                  = 1'b1;
                    n_mask[i_req.frame_index]  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_remove) n_count = r_count - CNT_W'(1);
        if (do_append) n_count = r_count + CNT_W'(1);

        // entries at or past the removed slot move down by one
        for (int i = 0; i < FRAMES; i++) begin
            after[i] = (sel & ({FRAMES{1'b1}} >> (FRAMES - 1 - i))) != '0;
        end

        for (int i = 0; i < FRAMES; i++) begin
            n_list[i] = r_list[i];
            if (do_remove && after[i] && (i < FRAMES - 1)) begin
                n_list[i] = r_list[(i + 1) % FRAMES];
            end
            if (do_append && (IDX_W'(i) == r_count[IDX_W-1:0])) begin
                n_list[i] = i_req.frame_index;
            end
        end

        o_res.occupancy = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_count <= '0;
        end else if (i_en) begin
            r_mask  <= n_mask;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_list <= n_list;
        end
    end

    assign o_status.member_mask = r_mask;
    assign o_status.entry_count = r_count;

endmodule

[rtl/core/lru_frame_replacer.sv]
// least-recently-unpinned frame replacer
// request channel i_req carries op (victim, pin, unpin) and frame_index;
// response channel o_rsp returns one item per request: victim_valid,
// victim_frame (zero unless a frame was evicted) and the occupancy after
// the op
// a request is taken into an input register, worked on against the held
// list combinationally and the answer lands in an output register, which
// drives o_rsp.valid; while o_rsp stalls, a request can wait in the input
// register before it is worked on
// throughput is one item per cycle while o_rsp does not stall; the held
// list is a row of 16 frame registers with a parallel compare on every slot
// and a one-slot shift down, so each op is combinational between the registers
// while o_rsp stalls, the finished response holds and the input register
// still takes one more item; after that i_req.ready drops until o_rsp.ready
// reset (synchronous, active low) empties the set: membership bits and
// count clear at once, list slots are left as they are and are only read
// below the count, so no clearing pass is needed
`include "assert_macros.svh"

module lru_frame_replacer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrufr_req_if.sink   i_req,
    lrufr_rsp_if.source o_rsp
);
    import lrufr_pkg::*;

    // input stage
    logic     r_in_valid;
    t_request r_in;
    // output stage
    logic     r_out_valid;
    t_result  r_out;

    logic     advance;
    t_result  res;
    t_status  status;

    // the work stage fires when the output register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) r_in_valid <= i_req.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.op          <= t_op'(i_req.op);
            r_in.frame_index <= i_req.frame_index;
        end
        if (advance) r_out <= res;
    end

    lrufr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_req    (r_in),
        .o_res    (res),
        .o_status (status)
    );

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.victim_valid = r_out.victim_valid;
    assign o_rsp.victim_frame = r_out.victim_frame;
    assign o_rsp.occupancy    = r_out.occupancy;

    // count always matches the number of membership bits
    `LRUFR_ASSERT(a_count_mask, $countones(status.member_mask) == int'(status.entry_count), "count and membership disagree")
    // the set never holds more than the list depth
    `LRUFR_ASSERT(a_count_max, status.entry_count <= CNT_W'(FRAMES), "count past list depth")
    // a response without an eviction reports frame zero
    `LRUFR_ASSERT_IMPLY(a_no_victim_zero, r_out_valid && !r_out.victim_valid, r_out.victim_frame == '0, "frame set without eviction")
    // a stalled response stays valid and keeps all its fields, occupancy included
    `LRUFR_ASSERT_IMPLY(a_stall_hold, r_out_valid && !o_rsp.ready, ##1 (r_out_valid && $stable(r_out)), "response changed while stalled")

endmodule
